// ===== hw/rtl/qev_pkg.sv =====
// shared types and constants for the quadrature encoder velocity estimator
// no dependencies; imported by qev_div and the top level
package qev_pkg;

  localparam int NUM_ENC = 2;
  localparam int CH_W = 1;

  localparam int DVD_W = 81;
  localparam int STEP_W = 7;
  localparam int QUO_W = 50;
  localparam int MAG_W = 48;

  localparam logic [STEP_W-1:0] VEL_STEPS = 7'd69;
  localparam logic [STEP_W-1:0] POS_STEPS = 7'd81;
  localparam logic [19:0] VEL_SCALE = 20'd1000000;

  localparam logic [2:0] CFG_COUNTS_PER_REV = 3'd0;
  localparam logic [2:0] CFG_LPF_ALPHA = 3'd1;
  localparam logic [2:0] CFG_INVERT_ENC0 = 3'd2;
  localparam logic [2:0] CFG_INVERT_ENC1 = 3'd3;
  localparam logic [2:0] CFG_NARROW_ENC0 = 3'd4;
  localparam logic [2:0] CFG_NARROW_ENC1 = 3'd5;

  typedef struct packed {
    logic [31:0] prev_raw;
    logic [31:0] prev_time;
    logic [63:0] accum;
    logic        seen;
    logic [31:0] filt;
    logic        seeded;
  } enc_ent_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [63:0]       divisor;
    logic [STEP_W-1:0] steps;
    logic              neg;
    logic              wide;
  } div_req_t;

endpackage

// ===== hw/rtl/qev_div.sv =====
// shared radix-2 restoring divider: rounded, saturated magnitude of num * 2^16 / den
// depends on qev_pkg
module qev_div (
  input  logic                          clk,
  input  logic                          rst,
  input  qev_pkg::div_req_t             req,
  output logic                          done,
  output logic [qev_pkg::MAG_W-1:0]     mag
);
  import qev_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t           dstate;
  logic [DVD_W-1:0]  dvd;
  logic [63:0]       den;
  logic [63:0]       rem;
  logic [QUO_W-1:0]  quo;
  logic              sticky;
  logic [STEP_W-1:0] cnt;
  logic [MAG_W-1:0]  limit;

  logic [64:0]       rs;
  logic [64:0]       rs_sub;
  logic              ge;
  logic [MAG_W-1:0]  lim_c;
  logic [32:0]       thr_hi;
  logic [QUO_W-1:0]  thresh;
  logic [QUO_W:0]    qp1;
  logic [QUO_W-1:0]  rnd;
  logic              sat;
  logic [MAG_W-1:0]  mag_c;

  assign rs = {rem, dvd[DVD_W-1]};
  assign rs_sub = rs - {1'b0, den};
  assign ge = rs >= {1'b0, den};

  always_comb begin
    if (req.wide) begin
      lim_c = req.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      lim_c = req.neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    end
  end

  assign thr_hi = {1'b0, limit[MAG_W-1:16]} + 33'd1;
  assign thresh = {thr_hi, 17'd0};
  assign qp1 = {1'b0, quo} + 51'd1;
  assign rnd = qp1[QUO_W:1];
  assign sat = sticky || (quo >= thresh);

  always_comb begin
    if (sat || (rnd > {2'b00, limit})) begin
      mag_c = limit;
    end else begin
      mag_c = rnd[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (req.start) begin
            dvd <= req.dividend;
            den <= req.divisor;
            rem <= '0;
            quo <= '0;
            sticky <= 1'b0;
            cnt <= req.steps;
            limit <= lim_c;
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          rem <= ge ? rs_sub[63:0] : rs[63:0];
          quo <= {quo[QUO_W-2:0], ge};
          sticky <= sticky | quo[QUO_W-1];
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            dstate <= D_FIN;
          end
        end
        D_FIN: begin
          mag <= mag_c;
          done <= 1'b1;
          dstate <= D_IDLE;
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/quadrature_encoder_velocity_estimator.sv =====
// a first sample goes only to the position divide; later ones accumulate, a nonzero time step
// adds the velocity multiplies and divide, then the filter; one sample is in flight at a time
// throughput is set by the shared one-bit-per-cycle divider (69 velocity + 81 position steps)
// a new sample is taken the cycle after its predecessor's result enters the output register
// reset restores the register defaults and marks both channel entries unwritten (read as zero)
// depends on qev_pkg and qev_div
module quadrature_encoder_velocity_estimator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qev_pkg::CH_W-1:0]   encoder_index,
  input  logic [31:0]                raw_counter,
  input  logic [31:0]                time_us,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [63:0]         total_count,
  output logic [31:0]                raw_count_echo,
  output logic signed [31:0]         raw_delta,
  output logic signed [31:0]         signed_delta_count,
  output logic signed [47:0]         position_q16,
  output logic signed [31:0]         velocity_q16,
  output logic                       velocity_valid,
  output logic [31:0]                time_echo,
  output logic                       is_narrow,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import qev_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_ACC, S_MULN, S_MULD, S_VDIV, S_VWAIT,
    S_FM1, S_FM2, S_FSUM, S_PDIV, S_PWAIT, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [31:0]        counts_per_rev;
  logic [15:0]        lpf_alpha_q16;
  logic [NUM_ENC-1:0] invert_enc;
  logic [NUM_ENC-1:0] narrow_enc;

  // per-channel state memory
  enc_ent_t           mem [NUM_ENC];
  logic [NUM_ENC-1:0] mem_vld;
  enc_ent_t           rd_data;
  logic               rd_vld;
  logic               mem_we;

  // working registers
  logic [CH_W-1:0]    ch;
  logic [31:0]        raw_in;
  logic [31:0]        t_in;
  enc_ent_t           ent;
  logic [31:0]        rawm;
  logic [31:0]        rdelta;
  logic [31:0]        sdelta;
  logic [31:0]        dt;
  logic [51:0]        num_v;
  logic [63:0]        den_v;
  logic [31:0]        vel_raw;
  logic [31:0]        vel;
  logic               vvalid;
  logic               nar;
  logic [MAG_W-1:0]   pos;
  logic signed [48:0] prod1;
  logic signed [49:0] prod2;

  // combinational helpers
  enc_ent_t           ent_in;
  logic               nar_c;
  logic               inv_c;
  logic [31:0]        rawm_c;
  logic [31:0]        diff_c;
  logic [31:0]        diff_x;
  logic [31:0]        vmag;
  logic [31:0]        cpr_eff;
  logic [63:0]        amag;
  logic [16:0]        w_new;
  logic signed [49:0] fsum;
  logic [31:0]        vel_c;
  logic [MAG_W-1:0]   pos_c;
  div_req_t           div_req;
  logic               div_done;
  logic [MAG_W-1:0]   div_mag;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_we = (state == S_DONE) && (!out_valid || out_ready);

  assign ent_in = rd_vld ? rd_data : '0;
  assign nar_c = narrow_enc[ch];
  assign inv_c = invert_enc[ch];
  assign rawm_c = nar_c ? {16'd0, raw_in[15:0]} : raw_in;
  assign diff_c = rawm_c - ent_in.prev_raw;
  assign diff_x = nar_c ? {{16{diff_c[15]}}, diff_c[15:0]} : diff_c;
  assign vmag = sdelta[31] ? 32'd0 - sdelta : sdelta;
  assign cpr_eff = (counts_per_rev == 32'd0) ? 32'd1 : counts_per_rev;
  assign amag = ent.accum[63] ? 64'd0 - ent.accum : ent.accum;
  assign w_new = 17'h10000 - {1'b0, lpf_alpha_q16};
  assign fsum = prod1 + prod2 + 50'sd32768;
  assign vel_c = sdelta[31] ? 32'd0 - div_mag[31:0] : div_mag[31:0];
  assign pos_c = ent.accum[63] ? 48'd0 - div_mag : div_mag;

  always_comb begin
    div_req = '0;
    case (state)
      S_VDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = {num_v, 29'd0};
        div_req.divisor = den_v;
        div_req.steps = VEL_STEPS;
        div_req.neg = sdelta[31];
        div_req.wide = 1'b0;
      end
      S_PDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = {amag, 17'd0};
        div_req.divisor = {32'd0, cpr_eff};
        div_req.steps = POS_STEPS;
        div_req.neg = ent.accum[63];
        div_req.wide = 1'b1;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  qev_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .mag  (div_mag)
  );

  // state memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ch] <= ent;
    end
    rd_data <= mem[encoder_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= mem_vld[encoder_index];
      if (mem_we) begin
        mem_vld[ch] <= 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= 32'd4096;
      lpf_alpha_q16 <= 16'd0;
      invert_enc <= 2'b00;
      narrow_enc <= 2'b10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COUNTS_PER_REV: counts_per_rev <= cfg_data;
        CFG_LPF_ALPHA:      lpf_alpha_q16 <= cfg_data[15:0];
        CFG_INVERT_ENC0:    invert_enc[0] <= cfg_data[0];
        CFG_INVERT_ENC1:    invert_enc[1] <= cfg_data[0];
        CFG_NARROW_ENC0:    narrow_enc[0] <= cfg_data[0];
        CFG_NARROW_ENC1:    narrow_enc[1] <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (mem_we) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch <= encoder_index;
            raw_in <= raw_counter;
            t_in <= time_us;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          ent <= '{prev_raw: rawm_c, prev_time: t_in, accum: ent_in.accum, seen: 1'b1,
                   filt: ent_in.filt, seeded: ent_in.seeded};
          rawm <= rawm_c;
          nar <= nar_c;
          vvalid <= 1'b0;
          vel <= 32'd0;
          dt <= t_in - ent_in.prev_time;
          if (!ent_in.seen) begin
            rdelta <= 32'd0;
            sdelta <= 32'd0;
            state <= S_PDIV;
          end else begin
            rdelta <= diff_x;
            sdelta <= inv_c ? 32'd0 - diff_x : diff_x;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          ent.accum <= ent.accum + {{32{sdelta[31]}}, sdelta};
          state <= (dt != 32'd0) ? S_MULN : S_PDIV;
        end
        S_MULN: begin
          num_v <= vmag * VEL_SCALE;
          state <= S_MULD;
        end
        S_MULD: begin
          den_v <= cpr_eff * dt;
          state <= S_VDIV;
        end
        S_VDIV: begin
          state <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_done) begin
            vvalid <= 1'b1;
            if (lpf_alpha_q16 == 16'd0) begin
              vel <= vel_c;
              state <= S_PDIV;
            end else if (!ent.seeded) begin
              ent <= '{prev_raw: ent.prev_raw, prev_time: ent.prev_time, accum: ent.accum,
                       seen: ent.seen, filt: vel_c, seeded: 1'b1};
              vel <= vel_c;
              state <= S_PDIV;
            end else begin
              vel_raw <= vel_c;
              state <= S_FM1;
            end
          end
        end
        S_FM1: begin
          prod1 <= $signed({1'b0, lpf_alpha_q16}) * $signed(ent.filt);
          state <= S_FM2;
        end
        S_FM2: begin
          prod2 <= $signed({1'b0, w_new}) * $signed(vel_raw);
          state <= S_FSUM;
        end
        S_FSUM: begin
          ent.filt <= fsum[47:16];
          vel <= fsum[47:16];
          state <= S_PDIV;
        end
        S_PDIV: begin
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (div_done) begin
            pos <= pos_c;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            total_count <= ent.accum;
            raw_count_echo <= rawm;
            raw_delta <= rdelta;
            signed_delta_count <= sdelta;
            position_q16 <= pos;
            velocity_q16 <= vel;
            velocity_valid <= vvalid;
            time_echo <= t_in;
            is_narrow <= nar;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the quadrature encoder velocity estimator
// predicts position, deltas and filtered velocity per encoder; depends on qev_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import qev_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 56;

  typedef struct packed {
    logic [63:0] total_count;
    logic [31:0] raw_count_echo;
    logic [31:0] raw_delta;
    logic [31:0] signed_delta_count;
    logic [47:0] position_q16;
    logic [31:0] velocity_q16;
    logic        velocity_valid;
    logic [31:0] time_echo;
    logic        is_narrow;
  } sample_result_t;

  typedef struct packed {
    bit             is_cfg;
    logic [2:0]     reg_idx;
    logic [31:0]    reg_val;
    logic           ch;
    logic [31:0]    raw;
    logic [31:0]    stamp;
    bit             typed;
    sample_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        encoder_index = 1'b0;
  logic [31:0] raw_counter = 32'd0;
  logic [31:0] time_us = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [63:0] total_count;
  logic [31:0] raw_count_echo;
  logic signed [31:0] raw_delta;
  logic signed [31:0] signed_delta_count;
  logic signed [47:0] position_q16;
  logic signed [31:0] velocity_q16;
  logic        velocity_valid;
  logic [31:0] time_echo;
  logic        is_narrow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  // register mirror
  bit [31:0] mir_cpr = 32'd4096;
  bit [15:0] mir_alpha = 16'd0;
  bit        mir_invert [2] = '{1'b0, 1'b0};
  bit        mir_narrow [2] = '{1'b0, 1'b1};

  // per-encoder state of the predictor
  bit [31:0] prior_raw [2];
  bit [31:0] last_time [2];
  bit [63:0] run_count [2];
  bit        got_first [2];
  bit [31:0] filt_vel [2];
  bit        filt_primed [2];

  sample_result_t results_due [$];
  int fail_count = 0;
  int quiet_cycles = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  plan_row_t plan [0:32] = '{
    '{1'b0, '0, '0, 1'b0, 32'h12345678, 32'd100, 1'b1,
      '{64'd0, 32'h12345678, 32'd0, 32'd0, 48'd0, 32'd0, 1'b0, 32'd100, 1'b0}},
    '{1'b0, '0, '0, 1'b1, 32'hFFFFABCD, 32'd200, 1'b1,
      '{64'd0, 32'h0000ABCD, 32'd0, 32'd0, 48'd0, 32'd0, 1'b0, 32'd200, 1'b1}},
    '{1'b0, '0, '0, 1'b0, 32'h12355678, 32'd100, 1'b1,
      '{64'd65536, 32'h12355678, 32'd65536, 32'd65536, 48'h100000, 32'd0, 1'b0,
        32'd100, 1'b0}},
    '{1'b0, '0, '0, 1'b0, 32'h12356678, 32'd1000100, 1'b1,
      '{64'd69632, 32'h12356678, 32'd4096, 32'd4096, 48'd1114112, 32'd65536, 1'b1,
        32'd1000100, 1'b0}},
    '{1'b0, '0, '0, 1'b1, 32'h00001234, 32'd300, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h0000F000, 32'd301, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h92356678, 32'd1000101, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h92356678, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h9235667F, 32'h00000010, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'hFFFFFFFF, 32'h00000020, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h00000000, 32'h00000021, 1'b0, '0},
    '{1'b1, CFG_LPF_ALPHA, 32'h0000FFFF, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_INVERT_ENC0, 32'd1, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_INVERT_ENC1, 32'd1, 1'b0, '0, '0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h00000100, 32'h00001000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h00000300, 32'h00002000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h80000300, 32'h00002001, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h00007FFF, 32'h00003000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h0000FFFF, 32'h00003000, 1'b0, '0},
    '{1'b1, CFG_LPF_ALPHA, 32'd1, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_NARROW_ENC0, 32'd1, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_NARROW_ENC1, 32'd0, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_COUNTS_PER_REV, 32'd1, 1'b0, '0, '0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'hABCD8000, 32'h00004000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h7FFFFFFF, 32'h00005000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'hFFFFFFFF, 32'h00005001, 1'b0, '0},
    '{1'b1, CFG_COUNTS_PER_REV, 32'd0, 1'b0, '0, '0, 1'b0, '0},
    '{1'b1, CFG_LPF_ALPHA, 32'h00008000, 1'b0, '0, '0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h00000001, 32'h00006000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h80000000, 32'hFFFFFF00, 1'b0, '0},
    '{1'b1, CFG_COUNTS_PER_REV, 32'hFFFFFFFF, 1'b0, '0, '0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 32'h0000FFFF, 32'h00007000, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 32'h00000000, 32'h00000000, 1'b0, '0}
  };

  quadrature_encoder_velocity_estimator dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .encoder_index      (encoder_index),
    .raw_counter        (raw_counter),
    .time_us            (time_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .total_count        (total_count),
    .raw_count_echo     (raw_count_echo),
    .raw_delta          (raw_delta),
    .signed_delta_count (signed_delta_count),
    .position_q16       (position_q16),
    .velocity_q16       (velocity_q16),
    .velocity_valid     (velocity_valid),
    .time_echo          (time_echo),
    .is_narrow          (is_narrow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // magnitude of num * 65536 / den, rounded half up, clipped to lim
  function automatic logic [63:0] q16_mag(logic [63:0] num, logic [63:0] den,
                                          logic [63:0] lim);
    logic [127:0] f;
    f = ({64'd0, num} << 17) / {64'd0, den};
    f = (f + 128'd1) >> 1;
    return (f > {64'd0, lim}) ? lim : f[63:0];
  endfunction

  function automatic logic [63:0] q16_signed(bit neg, logic [63:0] mag, logic [63:0] den,
                                             int bits);
    logic [63:0] lim;
    logic [63:0] v;
    lim = neg ? (64'd1 << (bits - 1)) : ((64'd1 << (bits - 1)) - 64'd1);
    v = q16_mag(mag, den, lim);
    return neg ? 64'd0 - v : v;
  endfunction

  function automatic logic [31:0] smooth_velocity(logic ch, logic [31:0] rv);
    logic signed [63:0] wa, wb, vo, vr, sum;
    if (mir_alpha == 16'd0) return rv;
    if (!filt_primed[ch]) begin
      filt_primed[ch] = 1'b1;
      filt_vel[ch] = rv;
      return rv;
    end
    wa = {48'd0, mir_alpha};
    wb = 64'sd65536 - wa;
    vo = {{32{filt_vel[ch][31]}}, filt_vel[ch]};
    vr = {{32{rv[31]}}, rv};
    sum = wa * vo + wb * vr;
    sum = (sum + 64'sd32768) >>> 16;
    filt_vel[ch] = sum[31:0];
    return sum[31:0];
  endfunction

  task automatic predict_sample(input logic ch, input logic [31:0] raw_in,
                                input logic [31:0] stamp, output sample_result_t r);
    logic [31:0] raw, diff, dt, sd, vmag;
    logic [63:0] den_cpr, acc, amag, pos, rv;
    bit narrow, vneg, aneg;
    narrow = mir_narrow[ch];
    den_cpr = (mir_cpr == 32'd0) ? 64'd1 : {32'd0, mir_cpr};
    raw = narrow ? (raw_in & 32'h0000FFFF) : raw_in;
    r = '0;
    r.raw_count_echo = raw;
    r.time_echo = stamp;
    r.is_narrow = narrow;
    if (!got_first[ch]) begin
      got_first[ch] = 1'b1;
    end else begin
      diff = raw - prior_raw[ch];
      dt = stamp - last_time[ch];
      if (narrow) diff = {{16{diff[15]}}, diff[15:0]};
      sd = mir_invert[ch] ? 32'd0 - diff : diff;
      r.raw_delta = diff;
      r.signed_delta_count = sd;
      run_count[ch] = run_count[ch] + {{32{sd[31]}}, sd};
      if (dt != 32'd0) begin
        vneg = sd[31];
        vmag = vneg ? 32'd0 - sd : sd;
        rv = q16_signed(vneg, {32'd0, vmag} * 64'd1000000, den_cpr * {32'd0, dt}, 32);
        r.velocity_q16 = smooth_velocity(ch, rv[31:0]);
        r.velocity_valid = 1'b1;
      end
    end
    prior_raw[ch] = raw;
    last_time[ch] = stamp;
    acc = run_count[ch];
    aneg = acc[63];
    amag = aneg ? 64'd0 - acc : acc;
    pos = q16_signed(aneg, amag, den_cpr, 48);
    r.total_count = acc;
    r.position_q16 = pos[47:0];
  endtask

  task automatic send_sample(input logic ch, input logic [31:0] raw, input logic [31:0] stamp,
                             input bit typed, input sample_result_t want);
    sample_result_t guess;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    encoder_index <= ch;
    raw_counter <= raw;
    time_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(ch, raw, stamp, guess);
    results_due.push_back(typed ? want : guess);
  endtask

  // drains the block before writing the register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COUNTS_PER_REV: mir_cpr = val;
      CFG_LPF_ALPHA:      mir_alpha = val[15:0];
      CFG_INVERT_ENC0:    mir_invert[0] = val[0];
      CFG_INVERT_ENC1:    mir_invert[1] = val[0];
      CFG_NARROW_ENC0:    mir_narrow[0] = val[0];
      CFG_NARROW_ENC1:    mir_narrow[1] = val[0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    sample_result_t want;
    out_ready <= ($urandom_range(99) >= out_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result, total_count %h", $time, total_count);
      end else begin
        want = results_due.pop_front();
        check_field("total_count", want.total_count, total_count);
        check_field("raw_count_echo", {32'd0, want.raw_count_echo}, {32'd0, raw_count_echo});
        check_field("raw_delta", {32'd0, want.raw_delta}, {32'd0, raw_delta});
        check_field("signed_delta_count", {32'd0, want.signed_delta_count},
                    {32'd0, signed_delta_count});
        check_field("position_q16", {16'd0, want.position_q16}, {16'd0, position_q16});
        check_field("velocity_q16", {32'd0, want.velocity_q16}, {32'd0, velocity_q16});
        check_field("velocity_valid", {63'd0, want.velocity_valid}, {63'd0, velocity_valid});
        check_field("time_echo", {32'd0, want.time_echo}, {32'd0, time_echo});
        check_field("is_narrow", {63'd0, want.is_narrow}, {63'd0, is_narrow});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph, n, mode;
    logic ch;
    logic [31:0] raw, stamp, step, dt, junk, cpr;
    logic [15:0] alpha;
    int in_idle_tbl [4];
    int out_stall_tbl [4];

    in_idle_tbl = '{0, 73, 0, 31};
    out_stall_tbl = '{0, 0, 73, 31};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_sample(plan[i].ch, plan[i].raw, plan[i].stamp, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      in_idle_pct = in_idle_tbl[ph % 4];
      out_stall_pct = out_stall_tbl[ph % 4];
      case (ph == 0 ? 0 : ph == 1 ? 1 : $urandom_range(5))
        0: cpr = 32'd1;
        1: cpr = 32'hFFFFFFFF;
        2: cpr = 32'd4096;
        3: cpr = $urandom_range(1, 100000);
        4: cpr = $urandom;
        default: cpr = 32'd0;
      endcase
      case (ph == 0 ? 1 : ph == 1 ? 0 : $urandom_range(3))
        0: alpha = 16'd0;
        1: alpha = 16'hFFFF;
        default: alpha = 16'($urandom_range(1, 16'hFFFE));
      endcase
      write_reg(CFG_COUNTS_PER_REV, cpr);
      junk = $urandom;
      write_reg(CFG_LPF_ALPHA, {junk[31:16], alpha});
      junk = $urandom;
      write_reg(CFG_INVERT_ENC0, {junk[31:1], 1'($urandom_range(1))});
      junk = $urandom;
      write_reg(CFG_INVERT_ENC1, {junk[31:1], 1'($urandom_range(1))});
      junk = $urandom;
      write_reg(CFG_NARROW_ENC0, {junk[31:1], 1'($urandom_range(1))});
      junk = $urandom;
      write_reg(CFG_NARROW_ENC1, {junk[31:1], 1'($urandom_range(1))});

      for (n = 0; n < PHASE_ITEMS; n++) begin
        ch = 1'($urandom_range(1));
        if ($urandom_range(99) < 12) begin
          raw = $urandom;
          stamp = $urandom;
        end else begin
          mode = $urandom_range(3);
          case (mode)
            0: step = $urandom_range(0, 16);
            1: step = $urandom_range(0, 5000);
            2: step = $urandom_range(0, 70000);
            default: step = $urandom;
          endcase
          if ($urandom_range(1)) step = 32'd0 - step;
          raw = prior_raw[ch] + step;
          mode = $urandom_range(99);
          if (mode < 6) dt = 32'd0;
          else if (mode < 40) dt = $urandom_range(1, 2000);
          else if (mode < 85) dt = $urandom_range(2000, 2000000);
          else dt = $urandom;
          stamp = last_time[ch] + dt;
        end
        send_sample(ch, raw, stamp, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
